// File: design/rpdt_pkg.sv
// shared types and constants for the receive port demux table
// used by rpdt_front, rpdt_back and receive_port_demux_table_top
package rpdt_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_DEREGISTER = 2'd1,
        OP_DELIVER    = 2'd2,
        OP_RANGE_DEL  = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [15:0] port;
        logic [7:0]  max_length;
        logic [15:0] ready_address;
        logic [15:0] data_address;
        logic [15:0] info_address;
        logic [7:0]  callback_id;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic [7:0]  packet_length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [7:0]  copy_length;
        logic [15:0] dest_address;
        logic [15:0] ready_target;
        logic [15:0] info_target;
        logic        write_info;
        logic [7:0]  post_callback;
        logic [3:0]  removed_count;
    } result_t;

endpackage

// File: design/rpdt_front.sv
// front end: takes requests, decodes the function code and queues them
// depends on rpdt_pkg
module rpdt_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_func,
    input  logic [15:0]   s_port,
    input  logic [7:0]    s_max_length,
    input  logic [15:0]   s_ready_address,
    input  logic [15:0]   s_data_address,
    input  logic [15:0]   s_info_address,
    input  logic [7:0]    s_callback_id,
    input  logic [15:0]   s_range_start,
    input  logic [15:0]   s_range_end,
    input  logic [7:0]    s_packet_length,
    output logic          q_valid,
    output rpdt_pkg::req_t q_req,
    input  logic          q_pop
);

    localparam int DEPTH = rpdt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rpdt_pkg::req_t queue_reg [DEPTH];
    rpdt_pkg::req_t in_req;
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;

    always_comb begin
        in_req.op            = rpdt_pkg::op_t'(s_func);
        in_req.port          = s_port;
        in_req.max_length    = s_max_length;
        in_req.ready_address = s_ready_address;
        in_req.data_address  = s_data_address;
        in_req.info_address  = s_info_address;
        in_req.callback_id   = s_callback_id;
        in_req.range_start   = s_range_start;
        in_req.range_end     = s_range_end;
        in_req.packet_length = s_packet_length;
    end

    assign s_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_req   = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// File: design/rpdt_back.sv
// back end: slot table, match and select sequencer, result register
// depends on rpdt_pkg
module rpdt_back #(
    parameter int SLOTS = rpdt_pkg::SLOTS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  rpdt_pkg::req_t    q_req,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output rpdt_pkg::result_t m_result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_SELECT = 4'b0100,
        ST_APPLY  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [7:0]  max_length;
        logic [15:0] data_address;
        logic [15:0] info_address;
        logic [7:0]  callback_id;
    } entry_t;

    state_t            state_reg;
    rpdt_pkg::req_t    cur_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [15:0]       slot_port_reg  [SLOTS];
    logic [15:0]       slot_ready_reg [SLOTS];
    entry_t            entry_mem [SLOTS];
    entry_t            rd_reg;
    logic [SLOTS-1:0]  hit_reg;
    logic [SLOTS-1:0]  hit_next;
    logic [IW-1:0]     sel_idx;
    logic [IW-1:0]     idx_reg;
    logic              any_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW+3:0]     cnt_ext;
    logic [IW+2:0]     idx_ext;
    logic              m_valid_reg;
    rpdt_pkg::result_t res_reg;
    rpdt_pkg::result_t res_next;
    entry_t            wr_entry;
    logic              apply_done;

    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign apply_done = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;
    assign m_result   = res_reg;
    assign idx_ext    = {3'b000, idx_reg};
    assign cnt_ext    = {4'b0000, cnt_reg};

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            case (cur_reg.op)
                rpdt_pkg::OP_REGISTER: begin
                    hit_next[i] = !valid_reg[i];
                end
                rpdt_pkg::OP_DEREGISTER, rpdt_pkg::OP_DELIVER: begin
                    hit_next[i] = valid_reg[i] && (slot_port_reg[i] == cur_reg.port);
                end
                default: begin
                    hit_next[i] = valid_reg[i]
                        && (slot_ready_reg[i] >= cur_reg.range_start)
                        && (slot_ready_reg[i] <= cur_reg.range_end);
                end
            endcase
        end
    end

    // first set bit wins
    always_comb begin
        sel_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                sel_idx = IW'(i);
            end
        end
    end

    always_comb begin
        wr_entry.max_length   = cur_reg.max_length;
        wr_entry.data_address = cur_reg.data_address;
        wr_entry.info_address = cur_reg.info_address;
        wr_entry.callback_id  = cur_reg.callback_id;
    end

    always_comb begin
        res_next = '0;
        case (cur_reg.op)
            rpdt_pkg::OP_REGISTER: begin
                if (any_reg) begin
                    res_next.slot = idx_ext[2:0];
                end else begin
                    res_next.status = rpdt_pkg::STATUS_FULL;
                end
            end
            rpdt_pkg::OP_DEREGISTER: begin
                if (any_reg) begin
                    res_next.slot          = idx_ext[2:0];
                    res_next.removed_count = 4'd1;
                end else begin
                    res_next.status = rpdt_pkg::STATUS_MISS;
                end
            end
            rpdt_pkg::OP_DELIVER: begin
                if (any_reg) begin
                    res_next.slot          = idx_ext[2:0];
                    res_next.copy_length   = (cur_reg.packet_length > rd_reg.max_length)
                                           ? rd_reg.max_length : cur_reg.packet_length;
                    res_next.dest_address  = rd_reg.data_address;
                    res_next.ready_target  = slot_ready_reg[idx_reg];
                    res_next.info_target   = rd_reg.info_address;
                    res_next.write_info    = (rd_reg.info_address != 16'd0);
                    res_next.post_callback = rd_reg.callback_id;
                end else begin
                    res_next.status = rpdt_pkg::STATUS_MISS;
                end
            end
            default: begin
                res_next.removed_count = (cnt_ext > (CW + 4)'(15)) ? 4'd15 : cnt_ext[3:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (apply_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    state_reg <= ST_SELECT;
                end
                ST_SELECT: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (apply_done) begin
                        state_reg <= ST_IDLE;
                        case (cur_reg.op)
                            rpdt_pkg::OP_REGISTER: begin
                                if (any_reg) begin
                                    valid_reg[idx_reg] <= 1'b1;
                                end
                            end
                            rpdt_pkg::OP_DEREGISTER: begin
                                if (any_reg) begin
                                    valid_reg[idx_reg] <= 1'b0;
                                end
                            end
                            rpdt_pkg::OP_RANGE_DEL: begin
                                valid_reg <= valid_reg & ~hit_reg;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_req;
        end
        if (state_reg == ST_MATCH) begin
            hit_reg <= hit_next;
        end
        if (state_reg == ST_SELECT) begin
            idx_reg <= sel_idx;
            any_reg <= |hit_reg;
            cnt_reg <= CW'($countones(hit_reg));
            rd_reg  <= entry_mem[sel_idx];
        end
        if (apply_done) begin
            res_reg <= res_next;
            if (cur_reg.op == rpdt_pkg::OP_REGISTER && any_reg) begin
                slot_port_reg[idx_reg]  <= cur_reg.port;
                slot_ready_reg[idx_reg] <= cur_reg.ready_address;
                entry_mem[idx_reg]      <= wr_entry;
            end
        end
    end

`ifndef ASSERT_OFF
    a_match_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY && cur_reg.op != rpdt_pkg::OP_REGISTER && any_reg)
        |-> valid_reg[idx_reg])
        else $error("selected slot is not valid");

    a_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY && cur_reg.op == rpdt_pkg::OP_REGISTER && any_reg)
        |-> !valid_reg[idx_reg])
        else $error("register picked an occupied slot");

    a_range_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply_done && cur_reg.op == rpdt_pkg::OP_RANGE_DEL)
        |=> ((valid_reg & $past(hit_reg)) == '0))
        else $error("range delete left a matching slot valid");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_APPLY))
        else $error("result appeared without an apply step");
`endif

endmodule

// File: design/receive_port_demux_table_top.sv
// receive port demux table: a request goes through the queue, match, select and apply
// steps before its result is valid; the back end sequencer handles one request at a time
// through its match/select/apply steps and holds in apply while a result waits to be taken
// a 2-entry request queue lets the front accept while a result waits to be taken
// reset (aresetn low, synchronous) clears all slot valid marks, the queue and the result valid
// depends on rpdt_pkg, rpdt_front, rpdt_back
module receive_port_demux_table_top #(
    parameter int SLOTS = rpdt_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_port,
    input  logic [7:0]  s_max_length,
    input  logic [15:0] s_ready_address,
    input  logic [15:0] s_data_address,
    input  logic [15:0] s_info_address,
    input  logic [7:0]  s_callback_id,
    input  logic [15:0] s_range_start,
    input  logic [15:0] s_range_end,
    input  logic [7:0]  s_packet_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_slot,
    output logic [7:0]  m_copy_length,
    output logic [15:0] m_dest_address,
    output logic [15:0] m_ready_target,
    output logic [15:0] m_info_target,
    output logic        m_write_info,
    output logic [7:0]  m_post_callback,
    output logic [3:0]  m_removed_count
);

    logic              q_valid;
    logic              q_pop;
    rpdt_pkg::req_t    q_req;
    rpdt_pkg::result_t result;

    rpdt_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_port          (s_port),
        .s_max_length    (s_max_length),
        .s_ready_address (s_ready_address),
        .s_data_address  (s_data_address),
        .s_info_address  (s_info_address),
        .s_callback_id   (s_callback_id),
        .s_range_start   (s_range_start),
        .s_range_end     (s_range_end),
        .s_packet_length (s_packet_length),
        .q_valid         (q_valid),
        .q_req           (q_req),
        .q_pop           (q_pop)
    );

    rpdt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_status        = result.status;
    assign m_slot          = result.slot;
    assign m_copy_length   = result.copy_length;
    assign m_dest_address  = result.dest_address;
    assign m_ready_target  = result.ready_target;
    assign m_info_target   = result.info_target;
    assign m_write_info    = result.write_info;
    assign m_post_callback = result.post_callback;
    assign m_removed_count = result.removed_count;

endmodule
